[hw/rtl/pidc_pkg.sv]
`timescale 1ns / 1ps

package pidc_pkg;

  localparam int DATA_W    = 32;
  localparam int LIM_W     = 31;
  localparam int FRAC_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int TERM_W    = PROD_W - FRAC_W;
  localparam int SUM_W     = TERM_W + 2;
  localparam int DIV_NUM_W = DATA_W + 1 + FRAC_W;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  localparam logic [DIV_NUM_W-1:0] Q_NEG_LIM =
    {{(DIV_NUM_W-DATA_W){1'b0}}, 1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DIV_NUM_W-1:0] Q_POS_LIM = Q_NEG_LIM - 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT   = 3'd5;

  localparam logic [LIM_W-1:0] PERIOD_RST = 31'd655;
  localparam logic [LIM_W-1:0] LIMIT_RST  = 31'h7FFF_FFFF;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_EDT,
    S_ADD_INT,
    S_MUL_P,
    S_MUL_I,
    S_ACC_I,
    S_WAIT_DIV,
    S_MUL_D,
    S_ACC_D,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    MUL_EDT,
    MUL_P,
    MUL_I,
    MUL_D
  } mul_sel_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  function automatic logic signed [DATA_W-1:0] clamp_sym(
    input logic signed [SUM_W-1:0] v,
    input logic [LIM_W-1:0] lim
  );
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    logic signed [SUM_W-1:0] res;
    hi = $signed({{(SUM_W-LIM_W){1'b0}}, lim});
    lo = -hi;
    if (v > hi) begin
      res = hi;
    end else if (v < lo) begin
      res = lo;
    end else begin
      res = v;
    end
    return res[DATA_W-1:0];
  endfunction

endpackage

[hw/rtl/pidc_div.sv]
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle: (diff << 16) / period, saturated
module pidc_div (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [pidc_pkg::DATA_W:0]      diff_i,
  input  logic        [pidc_pkg::LIM_W-1:0]     period_i,
  output pidc_pkg::div_sts_t                    sts_o,
  output logic signed [pidc_pkg::DATA_W-1:0]    deriv_o
);

  logic                                busy_r;
  logic                                done_r;
  logic                                neg_r;
  logic [pidc_pkg::DIV_CNT_W-1:0]      cnt_r;
  logic [pidc_pkg::DIV_NUM_W-1:0]      nq_r;
  logic [pidc_pkg::DIV_NUM_W-1:0]      nq_nxt;
  logic [pidc_pkg::LIM_W-1:0]          den_r;
  logic [pidc_pkg::LIM_W-1:0]          rem_r;
  logic [pidc_pkg::LIM_W-1:0]          rem_nxt;
  logic signed [pidc_pkg::DATA_W-1:0]  deriv_r;

  logic [pidc_pkg::DATA_W:0]           diff_mag;
  logic [pidc_pkg::LIM_W:0]            rem_sh;
  logic [pidc_pkg::LIM_W:0]            rem_sub;
  logic                                ge;
  logic [pidc_pkg::DATA_W-1:0]         sat_val;

  always_comb begin
    diff_mag = diff_i[pidc_pkg::DATA_W] ? (~diff_i + 1'b1) : diff_i;
    rem_sh   = {rem_r, nq_r[pidc_pkg::DIV_NUM_W-1]};
    rem_sub  = rem_sh - {1'b0, den_r};
    ge       = rem_sh >= {1'b0, den_r};
    rem_nxt  = ge ? rem_sub[pidc_pkg::LIM_W-1:0] : rem_sh[pidc_pkg::LIM_W-1:0];
    nq_nxt   = {nq_r[pidc_pkg::DIV_NUM_W-2:0], ge};
  end

  always_comb begin
    if (neg_r) begin
      if (nq_r > pidc_pkg::Q_NEG_LIM) begin
        sat_val = {1'b1, {(pidc_pkg::DATA_W-1){1'b0}}};
      end else begin
        sat_val = ~nq_r[pidc_pkg::DATA_W-1:0] + 1'b1;
      end
    end else begin
      if (nq_r > pidc_pkg::Q_POS_LIM) begin
        sat_val = {1'b0, {(pidc_pkg::DATA_W-1){1'b1}}};
      end else begin
        sat_val = nq_r[pidc_pkg::DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= pidc_pkg::DIV_CNT_W'(pidc_pkg::DIV_NUM_W);
      neg_r  <= diff_i[pidc_pkg::DATA_W];
      nq_r   <= {diff_mag, {pidc_pkg::FRAC_W{1'b0}}};
      den_r  <= (period_i == '0) ? pidc_pkg::LIM_W'(1) : period_i;
      rem_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        nq_r  <= nq_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
      end else begin
        deriv_r <= $signed(sat_val);
        busy_r  <= 1'b0;
        done_r  <= 1'b1;
      end
    end
  end

  assign sts_o.busy = busy_r;
  assign sts_o.done = done_r;
  assign deriv_o    = deriv_r;

endmodule

[hw/rtl/pid_controller_with_clamps_top.sv]
`timescale 1ns / 1ps

// PID controller, Q16.16, with integral and drive clamps.
// Input channel: in_valid/in_ready carry one signed error sample per request.
// Output channel: out_valid/out_ready carry one clamped drive per request.
// Config port: cfg_we writes cfg_wdata into register cfg_index
// (0 prop gain, 1 integ gain, 2 deriv gain, 3 period, 4 integ limit,
// 5 drive limit); other indexes are ignored. Write only while idle.
// One request at a time: a shared 32x32 multiplier forms e*period and the
// three gain products in turn, while a radix-2 divider computes the
// derivative, one quotient bit per cycle over 49 bits plus a saturate step.
// The divider sets the pace: the sequencer waits in S_WAIT_DIV for its
// result, and a new request is taken only after the previous one is done.
// The result sits in an output register; in_ready returns as soon as it is
// loaded, so a stalled receiver holds only the finished drive. If the output
// register is still full when the next result is done, the sequencer waits.
// Reset clears gains to zero, period to 655, both limits to full scale,
// and the integral and last error to zero.
module pid_controller_with_clamps_top (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [pidc_pkg::DATA_W-1:0]      in_error_sample,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [pidc_pkg::DATA_W-1:0]      out_drive,
  input  logic                                    cfg_we,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [pidc_pkg::DATA_W-1:0]             cfg_wdata
);

  pidc_pkg::state_t                     state_r;
  pidc_pkg::state_t                     state_nxt;
  pidc_pkg::mul_sel_t                   mul_sel;
  logic                                 mul_en;

  logic signed [pidc_pkg::DATA_W-1:0]   prop_gain_r;
  logic signed [pidc_pkg::DATA_W-1:0]   integ_gain_r;
  logic signed [pidc_pkg::DATA_W-1:0]   deriv_gain_r;
  logic [pidc_pkg::LIM_W-1:0]           period_r;
  logic [pidc_pkg::LIM_W-1:0]           integ_limit_r;
  logic [pidc_pkg::LIM_W-1:0]           drive_limit_r;

  logic signed [pidc_pkg::DATA_W-1:0]   err_r;
  logic signed [pidc_pkg::DATA_W-1:0]   last_err_r;
  logic signed [pidc_pkg::DATA_W-1:0]   integ_r;
  logic signed [pidc_pkg::PROD_W-1:0]   prod_r;
  logic signed [pidc_pkg::PROD_W-1:0]   prod_nxt;
  logic signed [pidc_pkg::SUM_W-1:0]    sum_r;
  logic                                 out_valid_r;
  logic                                 out_valid_nxt;
  logic signed [pidc_pkg::DATA_W-1:0]   out_drive_r;

  logic signed [pidc_pkg::DATA_W-1:0]   mul_a;
  logic signed [pidc_pkg::DATA_W-1:0]   mul_b;
  logic [pidc_pkg::LIM_W-1:0]           dt_eff;
  logic signed [pidc_pkg::TERM_W-1:0]   term;
  logic signed [pidc_pkg::SUM_W-1:0]    term_ext;
  logic signed [pidc_pkg::SUM_W-1:0]    int_sum;
  logic                                 in_acc;
  logic                                 out_free;

  pidc_pkg::div_sts_t                   div_sts;
  logic signed [pidc_pkg::DATA_W-1:0]   deriv;

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign dt_eff   = (period_r == '0) ? pidc_pkg::LIM_W'(1) : period_r;

  pidc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .diff_i   ((pidc_pkg::DATA_W + 1)'(in_error_sample) -
               (pidc_pkg::DATA_W + 1)'(last_err_r)),
    .period_i (period_r),
    .sts_o    (div_sts),
    .deriv_o  (deriv)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pidc_pkg::S_IDLE:     if (in_valid) state_nxt = pidc_pkg::S_MUL_EDT;
      pidc_pkg::S_MUL_EDT:  state_nxt = pidc_pkg::S_ADD_INT;
      pidc_pkg::S_ADD_INT:  state_nxt = pidc_pkg::S_MUL_P;
      pidc_pkg::S_MUL_P:    state_nxt = pidc_pkg::S_MUL_I;
      pidc_pkg::S_MUL_I:    state_nxt = pidc_pkg::S_ACC_I;
      pidc_pkg::S_ACC_I:    state_nxt = pidc_pkg::S_WAIT_DIV;
      pidc_pkg::S_WAIT_DIV: if (div_sts.done) state_nxt = pidc_pkg::S_MUL_D;
      pidc_pkg::S_MUL_D:    state_nxt = pidc_pkg::S_ACC_D;
      pidc_pkg::S_ACC_D:    state_nxt = pidc_pkg::S_DONE;
      pidc_pkg::S_DONE:     if (out_free) state_nxt = pidc_pkg::S_IDLE;
      default:              state_nxt = pidc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    mul_en   = 1'b0;
    mul_sel  = pidc_pkg::MUL_EDT;
    case (state_r)
      pidc_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      pidc_pkg::S_MUL_EDT: begin
        mul_en  = 1'b1;
        mul_sel = pidc_pkg::MUL_EDT;
      end
      pidc_pkg::S_MUL_P: begin
        mul_en  = 1'b1;
        mul_sel = pidc_pkg::MUL_P;
      end
      pidc_pkg::S_MUL_I: begin
        mul_en  = 1'b1;
        mul_sel = pidc_pkg::MUL_I;
      end
      pidc_pkg::S_MUL_D: begin
        mul_en  = 1'b1;
        mul_sel = pidc_pkg::MUL_D;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // shared multiplier
  always_comb begin
    case (mul_sel)
      pidc_pkg::MUL_EDT: begin
        mul_a = err_r;
        mul_b = $signed({1'b0, dt_eff});
      end
      pidc_pkg::MUL_P: begin
        mul_a = prop_gain_r;
        mul_b = err_r;
      end
      pidc_pkg::MUL_I: begin
        mul_a = integ_gain_r;
        mul_b = integ_r;
      end
      pidc_pkg::MUL_D: begin
        mul_a = deriv_gain_r;
        mul_b = deriv;
      end
      default: begin
        mul_a = err_r;
        mul_b = err_r;
      end
    endcase
    prod_nxt = pidc_pkg::PROD_W'(mul_a) * pidc_pkg::PROD_W'(mul_b);
  end

  // floor(prod / 2^16)
  assign term     = prod_r[pidc_pkg::PROD_W-1:pidc_pkg::FRAC_W];
  assign term_ext = pidc_pkg::SUM_W'(term);
  assign int_sum  = pidc_pkg::SUM_W'(integ_r) + term_ext;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == pidc_pkg::S_DONE && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pidc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      last_err_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        err_r      <= in_error_sample;
        last_err_r <= in_error_sample;
      end
      if (mul_en) begin
        prod_r <= prod_nxt;
      end
      case (state_r)
        pidc_pkg::S_ADD_INT: integ_r <= pidc_pkg::clamp_sym(int_sum, integ_limit_r);
        pidc_pkg::S_MUL_I:   sum_r   <= term_ext;
        pidc_pkg::S_ACC_I:   sum_r   <= sum_r + term_ext;
        pidc_pkg::S_ACC_D:   sum_r   <= sum_r + term_ext;
        pidc_pkg::S_DONE: begin
          if (out_free) begin
            out_drive_r <= pidc_pkg::clamp_sym(sum_r, drive_limit_r);
          end
        end
        default: begin
          sum_r <= sum_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r   <= '0;
      integ_gain_r  <= '0;
      deriv_gain_r  <= '0;
      period_r      <= pidc_pkg::PERIOD_RST;
      integ_limit_r <= pidc_pkg::LIMIT_RST;
      drive_limit_r <= pidc_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pidc_pkg::REG_PROP_GAIN:     prop_gain_r   <= $signed(cfg_wdata);
        pidc_pkg::REG_INTEG_GAIN:    integ_gain_r  <= $signed(cfg_wdata);
        pidc_pkg::REG_DERIV_GAIN:    deriv_gain_r  <= $signed(cfg_wdata);
        pidc_pkg::REG_SAMPLE_PERIOD: period_r      <= cfg_wdata[pidc_pkg::LIM_W-1:0];
        pidc_pkg::REG_INTEG_LIMIT:   integ_limit_r <= cfg_wdata[pidc_pkg::LIM_W-1:0];
        pidc_pkg::REG_DRIVE_LIMIT:   drive_limit_r <= cfg_wdata[pidc_pkg::LIM_W-1:0];
        default: begin
          prop_gain_r <= prop_gain_r;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;

  // a request keeps the sequencer busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after a request");

  // sequencer holds until the derivative is ready
  a_wait_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pidc_pkg::S_WAIT_DIV && !div_sts.done |=> state_r == pidc_pkg::S_WAIT_DIV)
    else $error("left divider wait early");

  // divider result is not flagged while it still iterates
  a_div_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> !div_sts.busy)
    else $error("divider done while busy");

endmodule
